// File: design/rpmc_pkg.sv
`default_nettype none

package rpmc_pkg;

    // Ring depth; a ring holds at most SLOTS-1 slots.
    localparam int SLOTS = 8;
    localparam int IDX_W = $clog2(SLOTS);

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        CMD_TX_ALLOC    = 3'd0,
        CMD_TX_FINALIZE = 3'd1,
        CMD_RX_TAKE     = 3'd2,
        CMD_RADIO_EVENT = 3'd3,
        CMD_TICK        = 3'd4,
        CMD_RX_START    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_ALLOC   = 2'd0,
        ST_DONE    = 2'd1,
        ST_SENDING = 2'd2
    } slot_state_t;

    typedef struct packed {
        logic [2:0] command;
        logic [2:0] slot;
        logic       event_ready;
        logic       event_end;
        logic       event_disabled;
        logic [6:0] rssi_sample;
    } item_t;

    typedef struct packed {
        logic       ok;
        logic       is_tx_slot;
        logic [2:0] slot_index;
        logic [6:0] packet_rssi;
        mode_t      radio_mode;
        logic       task_tx_enable;
        logic       task_rx_enable;
        logic       task_start;
        logic       task_disable;
        logic       task_rssi_stop;
        logic       short_rssi_start;
    } result_t;

    function automatic idx_t idx_inc(input idx_t i);
        return (i == idx_t'(SLOTS - 1)) ? '0 : idx_t'(i + 1'b1);
    endfunction

    function automatic idx_t idx_dec(input idx_t i);
        return (i == '0) ? idx_t'(SLOTS - 1) : idx_t'(i - 1'b1);
    endfunction

endpackage

`default_nettype wire

// File: design/rpmc_core.sv
`default_nettype none

// Ring state, slot stores and mode; one word processed per commit.
module rpmc_core
    import rpmc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    commit,
    input  wire item_t   item,
    output result_t      result
);

    idx_t  out_head_reg, out_head_next;
    idx_t  out_tail_reg, out_tail_next;
    idx_t  in_head_reg,  in_head_next;
    idx_t  in_tail_reg,  in_tail_next;
    mode_t mode_reg,     mode_next;
    logic  shortcut_reg, shortcut_next;

    // Slot stores, no reset: ring discipline writes before read.
    slot_state_t out_slot_state_reg [SLOTS];
    logic        in_slot_done_reg   [SLOTS];
    logic [6:0]  in_slot_rssi_reg   [SLOTS];

    logic        st_we;
    idx_t        st_waddr;
    slot_state_t st_wdata;
    logic        done_set_we;
    idx_t        done_set_addr;
    logic        done_clr_we;
    idx_t        done_clr_addr;

    idx_t        tx_front;
    idx_t        rx_tail_nt;
    logic        tx_pend_now;

    always_comb
    begin
        out_head_next = out_head_reg;
        out_tail_next = out_tail_reg;
        in_head_next  = in_head_reg;
        in_tail_next  = in_tail_reg;
        mode_next     = mode_reg;
        shortcut_next = shortcut_reg;
        st_we         = 1'b0;
        st_waddr      = out_tail_reg;
        st_wdata      = ST_ALLOC;
        done_set_we   = 1'b0;
        done_set_addr = idx_dec(in_tail_reg);
        done_clr_we   = 1'b0;
        done_clr_addr = in_tail_reg;
        tx_front      = out_head_reg;
        rx_tail_nt    = idx_inc(in_tail_reg);
        tx_pend_now   = (out_head_reg != out_tail_reg)
                        && (out_slot_state_reg[out_head_reg] == ST_DONE);
        result        = '0;

        case (item.command)
            CMD_TX_ALLOC:
            begin
                if (idx_inc(out_tail_reg) != out_head_reg)
                begin
                    st_we             = 1'b1;
                    result.ok         = 1'b1;
                    result.is_tx_slot = 1'b1;
                    result.slot_index = 3'(out_tail_reg);
                    out_tail_next     = idx_inc(out_tail_reg);
                end
            end
            CMD_TX_FINALIZE:
            begin
                if (32'(item.slot) < SLOTS)
                begin
                    st_we             = 1'b1;
                    st_waddr          = item.slot[IDX_W-1:0];
                    st_wdata          = ST_DONE;
                    result.ok         = 1'b1;
                    result.is_tx_slot = 1'b1;
                    result.slot_index = item.slot;
                end
            end
            CMD_RX_TAKE:
            begin
                if (in_head_reg != in_tail_reg && in_slot_done_reg[in_head_reg])
                begin
                    result.ok          = 1'b1;
                    result.slot_index  = 3'(in_head_reg);
                    result.packet_rssi = in_slot_rssi_reg[in_head_reg];
                    in_head_next       = idx_inc(in_head_reg);
                end
            end
            CMD_RADIO_EVENT:
            begin
                if (mode_reg == MODE_TX)
                begin
                    if (item.event_disabled)
                        result.task_tx_enable = 1'b1;
                    else if (item.event_end)
                    begin
                        // pop the sent front unless it is only allocated
                        if (out_head_reg != out_tail_reg
                            && out_slot_state_reg[out_head_reg] != ST_ALLOC)
                            tx_front = idx_inc(out_head_reg);
                    end
                    else if (item.event_ready)
                        shortcut_next = 1'b0;
                    out_head_next = tx_front;
                    if (item.event_end || item.event_ready)
                    begin
                        if (tx_front != out_tail_reg
                            && out_slot_state_reg[tx_front] == ST_DONE)
                        begin
                            st_we             = 1'b1;
                            st_waddr          = tx_front;
                            st_wdata          = ST_SENDING;
                            result.ok         = 1'b1;
                            result.is_tx_slot = 1'b1;
                            result.slot_index = 3'(tx_front);
                            result.task_start = 1'b1;
                        end
                        else
                        begin
                            mode_next           = MODE_RX;
                            result.task_disable = 1'b1;
                        end
                    end
                end
                else if (mode_reg == MODE_RX)
                begin
                    if (item.event_end)
                    begin
                        result.task_rssi_stop = 1'b1;
                        // close the packet just received, if any
                        done_set_we = (in_head_reg != in_tail_reg);
                        done_clr_we = 1'b1;
                        if (rx_tail_nt == in_head_reg)
                            in_head_next = idx_inc(in_head_reg);
                        in_tail_next      = rx_tail_nt;
                        result.slot_index = 3'(in_tail_reg);
                        result.ok         = 1'b1;
                        result.task_start = 1'b1;
                    end
                    else if (item.event_ready)
                    begin
                        shortcut_next     = 1'b1;
                        result.task_start = 1'b1;
                    end
                    else if (item.event_disabled)
                        result.task_rx_enable = 1'b1;
                end
            end
            CMD_TICK:
            begin
                if (tx_pend_now)
                begin
                    if (mode_reg == MODE_RX)
                    begin
                        mode_next           = MODE_TX;
                        result.task_disable = 1'b1;
                    end
                    else if (mode_reg == MODE_NONE)
                    begin
                        mode_next             = MODE_TX;
                        result.task_tx_enable = 1'b1;
                    end
                end
            end
            CMD_RX_START:
            begin
                shortcut_next = 1'b0;
                done_clr_we   = 1'b1;
                if (rx_tail_nt == in_head_reg)
                    in_head_next = idx_inc(in_head_reg);
                in_tail_next          = rx_tail_nt;
                result.slot_index     = 3'(in_tail_reg);
                result.ok             = 1'b1;
                mode_next             = MODE_RX;
                result.task_rx_enable = 1'b1;
            end
            default:
            begin
            end
        endcase

        result.radio_mode       = mode_next;
        result.short_rssi_start = shortcut_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_head_reg <= '0;
            out_tail_reg <= '0;
            in_head_reg  <= '0;
            in_tail_reg  <= '0;
            mode_reg     <= MODE_NONE;
            shortcut_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_head_reg <= out_head_next;
            out_tail_reg <= out_tail_next;
            in_head_reg  <= in_head_next;
            in_tail_reg  <= in_tail_next;
            mode_reg     <= mode_next;
            shortcut_reg <= shortcut_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            if (st_we)
                out_slot_state_reg[st_waddr] <= st_wdata;
            if (done_set_we)
            begin
                in_slot_done_reg[done_set_addr] <= 1'b1;
                in_slot_rssi_reg[done_set_addr] <= item.rssi_sample;
            end
            if (done_clr_we)
                in_slot_done_reg[done_clr_addr] <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: design/radio_packet_mailbox_controller.sv
// Radio packet mailbox controller. Keeps a transmit ring and a receive ring of
// rpmc_pkg::SLOTS slots each (at most SLOTS-1 in use per ring) plus the radio
// mode, and turns host commands (allocate, finalize, take, start receive),
// radio events and interval ticks into one result word per command word: a
// slot grant or packet pointer, the stored RSSI of a taken packet, the mode
// after the command, the task strobes and the RSSI shortcut setting.
// Throughput is one command word per clock cycle while the result side is not
// stalled: the whole update of pointers, slot flags and mode is combinational
// logic between the input register and the result register. Both channels are
// valid/ready; the input side keeps accepting while a result waits, as long
// as the input register is empty or can move into the result register. Slot
// flags are not cleared at reset; they are always written before the ring
// logic reads them.
`default_nettype none

module radio_packet_mailbox_controller
    import rpmc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] command,
    input  wire logic [2:0] slot,
    input  wire logic       event_ready,
    input  wire logic       event_end,
    input  wire logic       event_disabled,
    input  wire logic [6:0] rssi_sample,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            ok,
    output logic            is_tx_slot,
    output logic [2:0]      slot_index,
    output logic [6:0]      packet_rssi,
    output logic [1:0]      radio_mode,
    output logic            task_tx_enable,
    output logic            task_rx_enable,
    output logic            task_start,
    output logic            task_disable,
    output logic            task_rssi_stop,
    output logic            short_rssi_start
);

    // Input register: holds one command word until it can be processed.
    logic    in_full_reg;
    item_t   in_item_reg;

    // Result register: holds one result word until the consumer takes it.
    logic    res_full_reg;
    result_t res_reg;

    result_t core_result;
    logic    advance;

    // The held word is processed (state committed) as it moves to the result
    // register, which happens whenever that register is empty or draining.
    assign advance  = in_full_reg && (!res_full_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    rpmc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .item   (in_item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            res_full_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_full_reg <= 1'b1;
            else if (advance)
                in_full_reg <= 1'b0;

            if (advance)
                res_full_reg <= 1'b1;
            else if (out_ready)
                res_full_reg <= 1'b0;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg.command        <= command;
            in_item_reg.slot           <= slot;
            in_item_reg.event_ready    <= event_ready;
            in_item_reg.event_end      <= event_end;
            in_item_reg.event_disabled <= event_disabled;
            in_item_reg.rssi_sample    <= rssi_sample;
        end
        if (advance)
            res_reg <= core_result;
    end

    assign out_valid        = res_full_reg;
    assign ok               = res_reg.ok;
    assign is_tx_slot       = res_reg.is_tx_slot;
    assign slot_index       = res_reg.slot_index;
    assign packet_rssi      = res_reg.packet_rssi;
    assign radio_mode       = res_reg.radio_mode;
    assign task_tx_enable   = res_reg.task_tx_enable;
    assign task_rx_enable   = res_reg.task_rx_enable;
    assign task_start       = res_reg.task_start;
    assign task_disable     = res_reg.task_disable;
    assign task_rssi_stop   = res_reg.task_rssi_stop;
    assign short_rssi_start = res_reg.short_rssi_start;

endmodule

`default_nettype wire

// File: design/rpmc_checker.sv
`default_nettype none

module rpmc_checker
    import rpmc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic       ok,
    input  wire logic       is_tx_slot,
    input  wire logic [2:0] slot_index,
    input  wire logic [6:0] packet_rssi,
    input  wire logic [1:0] radio_mode,
    input  wire logic       task_tx_enable,
    input  wire logic       task_rx_enable,
    input  wire logic       task_start,
    input  wire logic       task_rssi_stop
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot_index) && $stable(ok)
            && $stable(radio_mode) && $stable(packet_rssi))
        else $error("result word changed while stalled");

    // No grant means no slot reference.
    a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> !is_tx_slot && slot_index == 3'd0)
        else $error("slot fields set without ok");

    // RSSI stop only comes with a new receive packet pointer, in receive mode.
    a_rssi_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && task_rssi_stop |-> ok && !is_tx_slot && task_start
            && radio_mode == MODE_RX)
        else $error("rssi stop outside receive packet end");

    // Receiver enable is only strobed while the mode is receive.
    a_rx_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && task_rx_enable |-> radio_mode == MODE_RX && !task_tx_enable)
        else $error("rx enable strobed outside receive mode");

    // Stored RSSI is only returned with a granted receive packet.
    a_rssi_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_rssi != 7'd0 |-> ok && !is_tx_slot)
        else $error("packet rssi without receive take");

endmodule

bind radio_packet_mailbox_controller rpmc_checker u_rpmc_checker (.*);

`default_nettype wire
